[src/wset_pkg.sv]
// Shared constants, codes and types for the windowed skeleton endpoint tracker.
// No dependencies; compile first.
package wset_pkg;

    // Image geometry
    localparam int LINE_WIDTH = 1024;
    localparam int MAX_ROWS   = 1024;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int HALF_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Derived counter and datapath widths
    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int ROW_W  = $clog2(MAX_ROWS + 2);
    localparam int SUM_W  = PIX_W + 3;
    localparam int CMP_W  = ((ROW_W > COL_W) ? ((ROW_W > POS_W) ? ROW_W : POS_W)
                                             : ((COL_W > POS_W) ? COL_W : POS_W)) + 1;

    // Zero words pushed after a frame end so every received pixel gets tested
    localparam int FLUSH_LEN = LINE_WIDTH + 1;
    localparam int FCNT_W    = $clog2(FLUSH_LEN + 1);

    // Foreground byte and required neighbor sum
    localparam logic [PIX_W-1:0] PIX_FG = 8'hFF;

    // Reset values of the configuration registers
    localparam logic [HALF_W-1:0] HALF_RST    = 7'd25;
    localparam logic [POS_W-1:0]  LEFT_X_RST  = 10'd26;
    localparam logic [POS_W-1:0]  LEFT_Y_RST  = 10'd87;
    localparam logic [POS_W-1:0]  RIGHT_X_RST = 10'd217;
    localparam logic [POS_W-1:0]  RIGHT_Y_RST = 10'd65;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_HALF   = 3'd0,
        REG_LEFT_START_X  = 3'd1,
        REG_LEFT_START_Y  = 3'd2,
        REG_RIGHT_START_X = 3'd3,
        REG_RIGHT_START_Y = 3'd4
    } reg_idx_t;

    // One column of the 3x3 neighborhood, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

endpackage

[src/wset_if.sv]
// Valid/ready channel interfaces: pixel stream in, endpoint results out.
// Depends on wset_pkg for field widths.
interface wset_pix_if;
    logic                      valid;
    logic                      ready;
    logic [wset_pkg::PIX_W-1:0] pixel;
    logic                      frame_start;
    logic                      frame_end;

    modport source (output valid, output pixel, output frame_start, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel, input frame_start, input frame_end,
                    output ready);
endinterface

interface wset_res_if;
    logic                      valid;
    logic                      ready;
    logic [wset_pkg::POS_W-1:0] left_x;
    logic [wset_pkg::POS_W-1:0] left_y;
    logic [wset_pkg::POS_W-1:0] right_x;
    logic [wset_pkg::POS_W-1:0] right_y;
    logic                      left_found;
    logic                      right_found;

    modport source (output valid, output left_x, output left_y, output right_x,
                    output right_y, output left_found, output right_found, input ready);
    modport sink   (input valid, input left_x, input left_y, input right_x,
                    input right_y, input left_found, input right_found, output ready);
endinterface

[src/windowed_skeleton_endpoint_tracker_core.sv]
// Windowed skeleton endpoint tracker, top level; uses wset_pkg, wset_pix_if, wset_res_if
// and wset_ram. Mask bytes stream in raster order, LINE_WIDTH per row, one word per clock
// while ready is high, with no gaps needed inside a frame. Two line stores share one RAM
// word per column; each incoming pixel reads the two rows above it, and stage 1 tests the
// 3x3 neighborhood centered one row up and one column left, with the window test in
// stage 2, so hits are judged in raster order. On the frame_end word the block stops
// taking pixels while it pushes zero pixels through the line stores to test the last rows,
// then drains the pipeline and waits for a free result slot; the result word waits in an
// output register, so the next frame may stream in before it is taken. A frame_start
// word discards a partial frame. Configuration writes load the window half size or a
// start coordinate directly into the tracked position; write only while the block is idle.
module windowed_skeleton_endpoint_tracker_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wset_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wset_pkg::CFG_DATA_W-1:0]     cfg_data,
    wset_pix_if.sink                            pixels,
    wset_res_if.source                          results
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    // Window membership: r in [py-h, py+h) and c in [px-h, px+h)
    function automatic logic in_win(
        input logic [wset_pkg::ROW_W-1:0]  r,
        input logic [wset_pkg::COL_W-1:0]  c,
        input logic [wset_pkg::POS_W-1:0]  px,
        input logic [wset_pkg::POS_W-1:0]  py,
        input logic [wset_pkg::HALF_W-1:0] h
    );
        logic [wset_pkg::CMP_W-1:0] rr;
        logic [wset_pkg::CMP_W-1:0] cc;
        logic [wset_pkg::CMP_W-1:0] xx;
        logic [wset_pkg::CMP_W-1:0] yy;
        logic [wset_pkg::CMP_W-1:0] hh;
        rr = wset_pkg::CMP_W'(r);
        cc = wset_pkg::CMP_W'(c);
        xx = wset_pkg::CMP_W'(px);
        yy = wset_pkg::CMP_W'(py);
        hh = wset_pkg::CMP_W'(h);
        return (rr + hh >= yy) && (rr < yy + hh) && (cc + hh >= xx) && (cc < xx + hh);
    endfunction

    // Control state
    state_t                           state_reg, state_next;
    logic [wset_pkg::FCNT_W-1:0]      flush_cnt_reg, flush_cnt_next;
    logic [wset_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [wset_pkg::COL_W-1:0]       col_reg, col_next;

    // Configuration and tracked positions
    logic [wset_pkg::HALF_W-1:0]      half_reg, half_next;
    logic [wset_pkg::POS_W-1:0]       lpx_reg, lpx_next, lpy_reg, lpy_next;
    logic [wset_pkg::POS_W-1:0]       rpx_reg, rpx_next, rpy_reg, rpy_next;

    // Hit flags and pending hit positions
    logic                             lhit_reg, lhit_next, rhit_reg, rhit_next;
    logic [wset_pkg::POS_W-1:0]       lhx_reg, lhx_next, lhy_reg, lhy_next;
    logic [wset_pkg::POS_W-1:0]       rhx_reg, rhx_next, rhy_reg, rhy_next;

    // Stage 1: pixel waits for its line store read
    logic                             s1_valid_reg;
    logic [wset_pkg::PIX_W-1:0]       s1_pixel_reg;
    logic [wset_pkg::ROW_W-1:0]       s1_row_reg;
    logic [wset_pkg::COL_W-1:0]       s1_col_reg;

    // Neighborhood columns to the left of the incoming one
    wset_pkg::column_t                win0_reg, win1_reg;

    // Stage 2: endpoint candidate waiting for the window test
    logic                             s2_valid_reg, s2_valid_next;
    logic [wset_pkg::ROW_W-1:0]       s2_row_reg;
    logic [wset_pkg::COL_W-1:0]       s2_col_reg;

    // Result register
    logic                             res_valid_reg, res_valid_next;
    logic [wset_pkg::POS_W-1:0]       res_lx_reg, res_ly_reg, res_rx_reg, res_ry_reg;
    logic                             res_lf_reg, res_rf_reg;

    // Datapath signals
    logic                             in_take;
    logic                             restart;
    logic                             feed;
    logic                             finish;
    logic [wset_pkg::PIX_W-1:0]       feed_pixel;
    logic [wset_pkg::ROW_W-1:0]       base_row;
    logic [wset_pkg::COL_W-1:0]       base_col;
    logic [2*wset_pkg::PIX_W-1:0]     rd_word;
    wset_pkg::column_t                new_col, right_col;
    logic                             first_col;
    logic [wset_pkg::SUM_W-1:0]       nb_sum;
    logic                             is_end;
    logic                             center_ok;
    logic [wset_pkg::ROW_W-1:0]       ctr_row;
    logic [wset_pkg::COL_W-1:0]       ctr_col;
    logic                             lwin, rwin;

    // Handshake and feed selection
    always_comb
    begin
        in_take    = pixels.valid && pixels.ready;
        restart    = in_take && pixels.frame_start;
        base_row   = restart ? '0 : row_reg;
        base_col   = restart ? '0 : col_reg;
        feed       = (in_take && (base_row < wset_pkg::ROW_W'(wset_pkg::MAX_ROWS)))
                     || (state_reg == ST_FLUSH);
        feed_pixel = (state_reg == ST_FLUSH) ? '0 : pixels.pixel;
        finish     = (state_reg == ST_DRAIN) && !s1_valid_reg && !s2_valid_reg
                     && (!res_valid_reg || results.ready);
    end

    assign pixels.ready = (state_reg == ST_RUN);

    // Raster position: advance per fed word, restart on frame start, clear at finish
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (finish)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (feed)
        begin
            if (base_col == wset_pkg::COL_W'(wset_pkg::LINE_WIDTH - 1))
            begin
                col_next = '0;
                row_next = base_row + wset_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = base_col + wset_pkg::COL_W'(1);
                row_next = base_row;
            end
        end
        else if (restart)
        begin
            row_next = base_row;
            col_next = base_col;
        end
    end

    // Frame sequencing: stream, push zeros, wait for pipeline and result slot
    always_comb
    begin
        state_next     = state_reg;
        flush_cnt_next = flush_cnt_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_take && pixels.frame_end)
                begin
                    state_next     = ST_FLUSH;
                    flush_cnt_next = '0;
                end
            end
            ST_FLUSH:
            begin
                flush_cnt_next = flush_cnt_reg + wset_pkg::FCNT_W'(1);
                if (flush_cnt_reg == wset_pkg::FCNT_W'(wset_pkg::FLUSH_LEN - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Line stores: upper byte holds row r-1, lower byte row r-2 at each column
    wset_ram #(
        .WIDTH (2 * wset_pkg::PIX_W),
        .DEPTH (wset_pkg::LINE_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_pixel_reg, rd_word[2*wset_pkg::PIX_W-1:wset_pkg::PIX_W]}),
        .rd_en   (feed),
        .rd_addr (base_col),
        .rd_data (rd_word)
    );

    // Stage 1: build the new column, mask rows not yet in this frame, sum neighbors
    always_comb
    begin
        new_col.top = (s1_row_reg > wset_pkg::ROW_W'(1)) ? rd_word[wset_pkg::PIX_W-1:0] : '0;
        new_col.mid = (s1_row_reg != '0)
                      ? rd_word[2*wset_pkg::PIX_W-1:wset_pkg::PIX_W] : '0;
        new_col.bot = s1_pixel_reg;
        first_col   = (s1_col_reg == '0);
        right_col   = first_col ? '0 : new_col;
        nb_sum      = wset_pkg::SUM_W'(win0_reg.top) + wset_pkg::SUM_W'(win0_reg.mid)
                    + wset_pkg::SUM_W'(win0_reg.bot) + wset_pkg::SUM_W'(win1_reg.top)
                    + wset_pkg::SUM_W'(win1_reg.bot) + wset_pkg::SUM_W'(right_col.top)
                    + wset_pkg::SUM_W'(right_col.mid) + wset_pkg::SUM_W'(right_col.bot);
        is_end      = (win1_reg.mid == wset_pkg::PIX_FG)
                      && (nb_sum == wset_pkg::SUM_W'(wset_pkg::PIX_FG));
        // At column 0 the center is the last column of the previous row
        center_ok   = first_col ? (s1_row_reg > wset_pkg::ROW_W'(1)) : (s1_row_reg != '0);
        ctr_row     = first_col ? (s1_row_reg - wset_pkg::ROW_W'(2))
                                : (s1_row_reg - wset_pkg::ROW_W'(1));
        ctr_col     = first_col ? wset_pkg::COL_W'(wset_pkg::LINE_WIDTH - 1)
                                : (s1_col_reg - wset_pkg::COL_W'(1));
        s2_valid_next = s1_valid_reg && center_ok && is_end && !restart;
    end

    // Stage 2: window test and first-hit capture
    always_comb
    begin
        lwin      = in_win(s2_row_reg, s2_col_reg, lpx_reg, lpy_reg, half_reg);
        rwin      = in_win(s2_row_reg, s2_col_reg, rpx_reg, rpy_reg, half_reg);
        lhit_next = lhit_reg;
        rhit_next = rhit_reg;
        lhx_next  = lhx_reg;
        lhy_next  = lhy_reg;
        rhx_next  = rhx_reg;
        rhy_next  = rhy_reg;
        if (restart || finish)
        begin
            lhit_next = 1'b0;
            rhit_next = 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (!lhit_reg && lwin)
            begin
                lhit_next = 1'b1;
                lhx_next  = wset_pkg::POS_W'(s2_col_reg);
                lhy_next  = wset_pkg::POS_W'(s2_row_reg);
            end
            if (!rhit_reg && rwin)
            begin
                rhit_next = 1'b1;
                rhx_next  = wset_pkg::POS_W'(s2_col_reg);
                rhy_next  = wset_pkg::POS_W'(s2_row_reg);
            end
        end
    end

    // Configuration writes and end-of-frame position update
    always_comb
    begin
        half_next = half_reg;
        lpx_next  = lpx_reg;
        lpy_next  = lpy_reg;
        rpx_next  = rpx_reg;
        rpy_next  = rpy_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                wset_pkg::REG_WINDOW_HALF:   half_next = cfg_data[wset_pkg::HALF_W-1:0];
                wset_pkg::REG_LEFT_START_X:  lpx_next  = cfg_data[wset_pkg::POS_W-1:0];
                wset_pkg::REG_LEFT_START_Y:  lpy_next  = cfg_data[wset_pkg::POS_W-1:0];
                wset_pkg::REG_RIGHT_START_X: rpx_next  = cfg_data[wset_pkg::POS_W-1:0];
                wset_pkg::REG_RIGHT_START_Y: rpy_next  = cfg_data[wset_pkg::POS_W-1:0];
                default:
                begin
                end
            endcase
        end
        else if (finish)
        begin
            if (lhit_reg)
            begin
                lpx_next = lhx_reg;
                lpy_next = lhy_reg;
            end
            if (rhit_reg)
            begin
                rpx_next = rhx_reg;
                rpy_next = rhy_reg;
            end
        end
    end

    // Result word: load at finish, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            flush_cnt_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            half_reg      <= wset_pkg::HALF_RST;
            lpx_reg       <= wset_pkg::LEFT_X_RST;
            lpy_reg       <= wset_pkg::LEFT_Y_RST;
            rpx_reg       <= wset_pkg::RIGHT_X_RST;
            rpy_reg       <= wset_pkg::RIGHT_Y_RST;
            lhit_reg      <= 1'b0;
            rhit_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            half_reg      <= half_next;
            lpx_reg       <= lpx_next;
            lpy_reg       <= lpy_next;
            rpx_reg       <= rpx_next;
            rpy_reg       <= rpy_next;
            lhit_reg      <= lhit_next;
            rhit_reg      <= rhit_next;
            s1_valid_reg  <= feed;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lhx_reg <= lhx_next;
        lhy_reg <= lhy_next;
        rhx_reg <= rhx_next;
        rhy_reg <= rhy_next;
        if (feed)
        begin
            s1_pixel_reg <= feed_pixel;
            s1_row_reg   <= base_row;
            s1_col_reg   <= base_col;
        end
        // Shift the neighborhood; a new row starts with a zero left column
        if (s1_valid_reg)
        begin
            win0_reg <= first_col ? '0 : win1_reg;
            win1_reg <= new_col;
        end
        s2_row_reg <= ctr_row;
        s2_col_reg <= ctr_col;
        if (finish)
        begin
            res_lx_reg <= lhit_reg ? lhx_reg : lpx_reg;
            res_ly_reg <= lhit_reg ? lhy_reg : lpy_reg;
            res_rx_reg <= rhit_reg ? rhx_reg : rpx_reg;
            res_ry_reg <= rhit_reg ? rhy_reg : rpy_reg;
            res_lf_reg <= lhit_reg;
            res_rf_reg <= rhit_reg;
        end
    end

    // Drive result channel
    assign results.valid       = res_valid_reg;
    assign results.left_x      = res_lx_reg;
    assign results.left_y      = res_ly_reg;
    assign results.right_x     = res_rx_reg;
    assign results.right_y     = res_ry_reg;
    assign results.left_found  = res_lf_reg;
    assign results.right_found = res_rf_reg;

`ifndef SYNTHESIS
    // Every flush cycle pushes a zero word into the line stores
    a_flush_feeds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |=> s1_valid_reg)
        else $error("flush cycle did not feed the line stores");

    // A fresh result is only loaded once the test pipeline is empty
    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(!s1_valid_reg && !s2_valid_reg))
        else $error("result loaded with tests still in flight");

    // Streaming resumes after a frame with the hit flags cleared
    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == ST_DRAIN) && state_reg == ST_RUN) |-> (!lhit_reg && !rhit_reg))
        else $error("hit flags survived the end of a frame");
`endif

endmodule

[src/wset_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wset_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[dv/windowed_skeleton_endpoint_tracker_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for windowed_skeleton_endpoint_tracker_core: streams mask frames,
// predicts the endpoint words in a local line-store model and compares each result field.
// Depends on wset_pkg, wset_pix_if and wset_res_if from the RTL.
module windowed_skeleton_endpoint_tracker_core_tb;
    import wset_pkg::*;

    localparam int BAND_UP   = 0;
    localparam int BAND_MID  = 1;
    localparam int BAND_CUR  = 2;
    localparam int BAND_ZERO = 3;
    localparam int PHASE_GAP = 32;
    localparam int RANDOM_ITEMS = 850;
    localparam int STEADY_ITEMS = 100;

    typedef struct {
        logic [POS_W-1:0] lx;
        logic [POS_W-1:0] ly;
        logic [POS_W-1:0] rx;
        logic [POS_W-1:0] ry;
        logic             lf;
        logic             rf;
    } track_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wset_pix_if pix_ch ();
    wset_res_if res_ch ();

    windowed_skeleton_endpoint_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    always #2 clk = ~clk;

    // Tracker model state
    logic [PIX_W-1:0] band [0:3][0:LINE_WIDTH-1];
    logic [HALF_W-1:0] half_size;
    logic [POS_W-1:0]  lp_x, lp_y, rp_x, rp_y;
    logic [POS_W-1:0]  l_hit_x, l_hit_y, r_hit_x, r_hit_y;
    bit                l_hit, r_hit;
    int                col_cnt, row_cnt;

    track_t expected_tracks [$];
    track_t want_track;
    int     mismatch_count = 0;
    int     items_sent = 0;
    bit     gaps_on = 1'b1;
    bit     stalls_on = 1'b1;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Start a new frame: empty the line stores, counters and pending hits
    function automatic void clear_frame();
        for (int b = BAND_UP; b <= BAND_CUR; b++)
            for (int c = 0; c < LINE_WIDTH; c++)
                band[b][c] = '0;
        col_cnt = 0;
        row_cnt = 0;
        l_hit = 1'b0;
        r_hit = 1'b0;
        l_hit_x = '0;
        l_hit_y = '0;
        r_hit_x = '0;
        r_hit_y = '0;
    endfunction

    function automatic void reset_tracker_model();
        for (int c = 0; c < LINE_WIDTH; c++)
            band[BAND_ZERO][c] = '0;
        half_size = HALF_RST;
        lp_x = LEFT_X_RST;
        lp_y = LEFT_Y_RST;
        rp_x = RIGHT_X_RST;
        rp_y = RIGHT_Y_RST;
        clear_frame();
    endfunction

    function automatic int band_at(int sel, int c);
        if (c < 0 || c >= LINE_WIDTH)
            return 0;
        return int'(band[sel][c]);
    endfunction

    function automatic bit in_search(logic [POS_W-1:0] px, logic [POS_W-1:0] py, int r, int c);
        int h;
        h = int'(half_size);
        return r >= int'(py) - h && r < int'(py) + h && c >= int'(px) - h && c < int'(px) + h;
    endfunction

    // Test each pixel of row r; a, m, b select the bands holding rows r-1, r, r+1
    function automatic void scan_line(int r, int a, int m, int b);
        int sum;
        for (int c = 0; c < LINE_WIDTH; c++) begin
            if (band[m][c] != PIX_FG)
                continue;
            sum = band_at(a, c - 1) + band_at(a, c) + band_at(a, c + 1) +
                  band_at(m, c - 1) + band_at(m, c + 1) +
                  band_at(b, c - 1) + band_at(b, c) + band_at(b, c + 1);
            if (sum != int'(PIX_FG))
                continue;
            if (!l_hit && in_search(lp_x, lp_y, r, c)) begin
                l_hit = 1'b1;
                l_hit_x = POS_W'(c);
                l_hit_y = POS_W'(r);
            end
            if (!r_hit && in_search(rp_x, rp_y, r, c)) begin
                r_hit = 1'b1;
                r_hit_x = POS_W'(c);
                r_hit_y = POS_W'(r);
            end
        end
    endfunction

    // Take one accepted pixel word; queue the endpoint word on a frame end
    function automatic void advance_tracker(logic [PIX_W-1:0] px, bit fs, bit fe);
        track_t rec;
        if (fs)
            clear_frame();
        if (row_cnt < MAX_ROWS) begin
            band[BAND_CUR][col_cnt] = px;
            if (col_cnt == LINE_WIDTH - 1) begin
                if (row_cnt >= 1)
                    scan_line(row_cnt - 1, BAND_UP, BAND_MID, BAND_CUR);
                for (int c = 0; c < LINE_WIDTH; c++) begin
                    band[BAND_UP][c] = band[BAND_MID][c];
                    band[BAND_MID][c] = band[BAND_CUR][c];
                    band[BAND_CUR][c] = '0;
                end
                col_cnt = 0;
                row_cnt++;
            end else begin
                col_cnt++;
            end
        end
        if (!fe)
            return;
        if (col_cnt > 0) begin
            if (row_cnt >= 1)
                scan_line(row_cnt - 1, BAND_UP, BAND_MID, BAND_CUR);
            scan_line(row_cnt, BAND_MID, BAND_CUR, BAND_ZERO);
        end else if (row_cnt >= 1) begin
            scan_line(row_cnt - 1, BAND_UP, BAND_MID, BAND_ZERO);
        end
        if (l_hit) begin
            lp_x = l_hit_x;
            lp_y = l_hit_y;
        end
        if (r_hit) begin
            rp_x = r_hit_x;
            rp_y = r_hit_y;
        end
        rec = '{lx: lp_x, ly: lp_y, rx: rp_x, ry: rp_y, lf: l_hit, rf: r_hit};
        expected_tracks.push_back(rec);
        clear_frame();
    endfunction

    // Send one pixel word, with an optional idle burst ahead of it
    task automatic send_pixel(logic [PIX_W-1:0] px, bit fs, bit fe);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= px;
        pix_ch.frame_start <= fs;
        pix_ch.frame_end   <= fe;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        advance_tracker(px, fs, fe);
        items_sent++;
    endtask

    // Hold the input, wait for every pending endpoint word, then let the block go quiet
    task automatic settle(int tail);
        pix_ch.valid <= 1'b0;
        while (expected_tracks.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_WINDOW_HALF:   half_size = val[HALF_W-1:0];
            REG_LEFT_START_X:  lp_x = val;
            REG_LEFT_START_Y:  lp_y = val;
            REG_RIGHT_START_X: rp_x = val;
            REG_RIGHT_START_Y: rp_y = val;
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block is idle
    task automatic load_settings(logic [HALF_W-1:0] half, logic [POS_W-1:0] lx,
                                 logic [POS_W-1:0] ly, logic [POS_W-1:0] rx,
                                 logic [POS_W-1:0] ry);
        settle(PHASE_GAP);
        put_reg(REG_WINDOW_HALF, CFG_DATA_W'(half));
        put_reg(REG_LEFT_START_X, lx);
        put_reg(REG_LEFT_START_Y, ly);
        put_reg(REG_RIGHT_START_X, rx);
        put_reg(REG_RIGHT_START_Y, ry);
        cfg_write <= 1'b0;
    endtask

    // Stream one frame; content is dense below dense_cols and sparse beyond
    task automatic send_frame(int len, bit lead_mark, int restart_at, int dense_cols);
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] carry;
        bit pair_next;
        int col;
        int r;
        pair_next = 1'b0;
        carry = '0;
        for (int i = 0; i < len; i++) begin
            col = i % LINE_WIDTH;
            if (pair_next) begin
                // complement of a stray byte, so the two sum to foreground
                px = PIX_FG - carry;
                pair_next = 1'b0;
            end else if (col < dense_cols) begin
                r = $urandom_range(0, 19);
                if (r < 10) begin
                    px = '0;
                end else if (r < 17) begin
                    px = PIX_FG;
                end else begin
                    px = PIX_W'($urandom_range(0, 255));
                    carry = px;
                    pair_next = $urandom_range(0, 1);
                end
            end else begin
                px = ($urandom_range(0, 63) == 0) ? PIX_FG : '0;
            end
            send_pixel(px, (i == 0 && lead_mark) || i == restart_at, i == len - 1);
        end
    endtask

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 5))
            0: return HALF_W'(1);
            1: return HALF_W'(64);
            default: return HALF_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_col();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return POS_W'($urandom_range(0, 1023));
            default: return POS_W'($urandom_range(0, 60));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_row();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return POS_W'($urandom_range(0, 1023));
            default: return POS_W'($urandom_range(0, 70));
        endcase
    endfunction

    // Reset windows lie below row 0, so a short frame finds nothing
    task automatic test_reset_defaults();
        send_pixel(PIX_FG, 1'b1, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
    endtask

    // Both marks on one word, then a frame with no start mark
    task automatic test_one_pixel_frames();
        load_settings(HALF_W'(64), POS_W'(0), POS_W'(0), POS_W'(5), POS_W'(1));
        send_pixel(PIX_FG, 1'b1, 1'b1);
        send_pixel(PIX_FG, 1'b0, 1'b1);
    endtask

    // Endpoints along one row: a foreground pair and a split neighbor sum
    task automatic test_row_endpoints();
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h80, 1'b0, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(8'h7F, 1'b0, 1'b1);
    endtask

    // A start mark inside a frame drops what came before it
    task automatic test_frame_restart();
        send_pixel(PIX_FG, 1'b1, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b1);
    endtask

    // Smallest window, hanging off the top left corner of the image
    task automatic test_narrow_window();
        load_settings(HALF_W'(1), POS_W'(1), POS_W'(0), POS_W'(0), POS_W'(0));
        send_pixel(PIX_FG, 1'b1, 1'b0);
        send_pixel(PIX_FG, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
    endtask

    // Frames of whole and partial rows, so vertical neighbors count
    task automatic test_multi_row();
        int len;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: len = LINE_WIDTH;
                1: len = 2 * LINE_WIDTH;
                2: len = 2 * LINE_WIDTH + $urandom_range(1, 60);
                default: len = LINE_WIDTH + $urandom_range(1, 60);
            endcase
            load_settings(HALF_W'($urandom_range(2, 64)),
                          POS_W'($urandom_range(0, 90)), POS_W'($urandom_range(0, 3)),
                          POS_W'($urandom_range(0, 90)), POS_W'($urandom_range(0, 3)));
            send_frame(len, 1'b1, -1, 96);
        end
    endtask

    // Short frames with random content; settings and idling change every few frames
    task automatic test_random_frames();
        int goal;
        int frames;
        int len;
        int restart_at;
        goal = items_sent + RANDOM_ITEMS;
        frames = 0;
        while (items_sent < goal) begin
            if (frames % 6 == 0) begin
                gaps_on = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
                load_settings(pick_half(), pick_col(), pick_row(), pick_col(), pick_row());
            end
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
            restart_at = (len > 2 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
            send_frame(len, $urandom_range(0, 3) != 0, restart_at, LINE_WIDTH);
            frames++;
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_steady_stream();
        int goal;
        load_settings(pick_half(), POS_W'($urandom_range(0, 40)), POS_W'(0),
                      POS_W'($urandom_range(0, 40)), POS_W'(0));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        goal = items_sent + STEADY_ITEMS;
        while (items_sent < goal)
            send_frame($urandom_range(2, 30), 1'b1, -1, LINE_WIDTH);
    endtask

    // Result-side ready with random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted endpoint word with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_tracks.size() == 0) begin
                report_mismatch("endpoint word with no frame pending");
            end else begin
                want_track = expected_tracks.pop_front();
                if (res_ch.left_x !== want_track.lx)
                    report_mismatch($sformatf("left_x got %0d want %0d",
                                              res_ch.left_x, want_track.lx));
                if (res_ch.left_y !== want_track.ly)
                    report_mismatch($sformatf("left_y got %0d want %0d",
                                              res_ch.left_y, want_track.ly));
                if (res_ch.right_x !== want_track.rx)
                    report_mismatch($sformatf("right_x got %0d want %0d",
                                              res_ch.right_x, want_track.rx));
                if (res_ch.right_y !== want_track.ry)
                    report_mismatch($sformatf("right_y got %0d want %0d",
                                              res_ch.right_y, want_track.ry));
                if (res_ch.left_found !== want_track.lf)
                    report_mismatch($sformatf("left_found got %0b want %0b",
                                              res_ch.left_found, want_track.lf));
                if (res_ch.right_found !== want_track.rf)
                    report_mismatch($sformatf("right_found got %0b want %0b",
                                              res_ch.right_found, want_track.rf));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_WINDOW_HALF;
        cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        pix_ch.frame_start <= 1'b0;
        pix_ch.frame_end <= 1'b0;
        reset_tracker_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_one_pixel_frames();
        test_row_endpoints();
        test_frame_restart();
        test_narrow_window();
        test_multi_row();
        test_random_frames();
        test_steady_stream();

        settle(LINE_WIDTH + 32);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[windowed_skeleton_endpoint_tracker_core.f]
src/wset_pkg.sv
src/wset_if.sv
src/wset_ram.sv
src/windowed_skeleton_endpoint_tracker_core.sv
dv/windowed_skeleton_endpoint_tracker_core_tb.sv
